// ----- rtl/wrt_pkg.sv -----
package wrt_pkg;

  localparam int DEF_NUM_STATES  = 15;
  localparam int DEF_NUM_ACTIONS = 7;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int PROBES  = 8;
  localparam int PROBE_W = $clog2(PROBES);

  localparam int OPC_W = 2;
  localparam int IDX_S_W = 4;
  localparam int IDX_A_W = 3;
  localparam int IO_VAL_W = 32;

  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

endpackage

// ----- rtl/wrt_mem.sv -----
module wrt_mem #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);
  import wrt_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/wrt_cmp.sv -----
module wrt_cmp #(
  parameter int WIDTH = wrt_pkg::DEF_VALUE_WIDTH
) (
  input  logic signed [WIDTH-1:0] lhs,
  input  logic signed [WIDTH-1:0] rhs,
  output logic                    lt,
  output logic signed [WIDTH-1:0] low
);
  import wrt_pkg::*;

  // signed less-than, shared by the min and max updates
  assign lt  = lhs < rhs;
  assign low = lt ? lhs : rhs;

endmodule

// ----- rtl/wildcard_reward_table.sv -----
// A write passes ST_WMIN and ST_WMAX, a read ST_RISS and ST_RCHK per probe,
// a clear sweeps all DEPTH entries, an unused opcode goes straight to done.
// One item at a time: a single-port table memory and one shared comparator
// serve every step, and each read probe takes an address and a data step.
// After reset the table valid bits are swept clear over all DEPTH entries
// (2048 by default), and no beat is taken until the sweep ends.
module wildcard_reward_table #(
  parameter int NUM_STATES  = wrt_pkg::DEF_NUM_STATES,
  parameter int NUM_ACTIONS = wrt_pkg::DEF_NUM_ACTIONS,
  parameter int VALUE_WIDTH = wrt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wrt_pkg::OPC_W-1:0]           in_opcode,
  input  logic [wrt_pkg::IDX_S_W-1:0]         in_cur_state,
  input  logic                                in_cur_wild,
  input  logic [wrt_pkg::IDX_A_W-1:0]         in_action_index,
  input  logic                                in_action_wild,
  input  logic [wrt_pkg::IDX_S_W-1:0]         in_next_state,
  input  logic                                in_next_wild,
  input  logic signed [wrt_pkg::IO_VAL_W-1:0] in_value_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wrt_pkg::IO_VAL_W-1:0] out_read_value,
  output logic                                out_hit,
  output logic signed [wrt_pkg::IO_VAL_W-1:0] out_min_value,
  output logic signed [wrt_pkg::IO_VAL_W-1:0] out_max_value
);
  import wrt_pkg::*;

  localparam int SKEYS  = NUM_STATES + 1;
  localparam int AKEYS  = NUM_ACTIONS + 1;
  localparam int DEPTH  = SKEYS * AKEYS * SKEYS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SKW    = $clog2(SKEYS);
  localparam int AKW    = $clog2(AKEYS);
  localparam int VW     = VALUE_WIDTH;

  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_WMIN = 3'd2;
  localparam logic [2:0] ST_WMAX = 3'd3;
  localparam logic [2:0] ST_RISS = 3'd4;
  localparam logic [2:0] ST_RCHK = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               clr_op_r, clr_op_nxt;
  logic [PROBE_W-1:0] probe_r, probe_nxt;
  logic [SKW-1:0]     s_r, s_nxt, n_r, n_nxt;
  logic [AKW-1:0]     a_r, a_nxt;
  logic [OPC_W-1:0]   op_r, op_nxt;
  logic signed [VW-1:0] v_r, v_nxt;
  logic signed [VW-1:0] min_r, min_nxt, max_r, max_nxt;
  logic signed [VW-1:0] res_value_r, res_value_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [IO_VAL_W-1:0] out_value_r, out_value_nxt;
  logic                       out_hit_r, out_hit_nxt;
  logic signed [IO_VAL_W-1:0] out_min_r, out_min_nxt, out_max_r, out_max_nxt;

  logic               in_acc;
  logic               out_free;
  logic [SKW-1:0]     ps, pn;
  logic [AKW-1:0]     pa;
  logic [ADDR_W-1:0]  probe_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [VW:0]        mem_wdata, mem_rdata;
  logic signed [VW-1:0] cmp_lhs, cmp_rhs, cmp_low;
  logic                 cmp_lt;
  logic signed [63:0]   vin64, sat64;
  logic signed [63:0]   rv64, mn64, mx64;
  logic [SKW-1:0]       s_key, n_key;
  logic [AKW-1:0]       a_key;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign s_key = (in_cur_wild || 32'(in_cur_state) >= NUM_STATES) ?
                 SKW'(NUM_STATES) : SKW'(in_cur_state);
  assign n_key = (in_next_wild || 32'(in_next_state) >= NUM_STATES) ?
                 SKW'(NUM_STATES) : SKW'(in_next_state);
  assign a_key = (in_action_wild || 32'(in_action_index) >= NUM_ACTIONS) ?
                 AKW'(NUM_ACTIONS) : AKW'(in_action_index);

  assign vin64 = 64'(in_value_in);
  assign sat64 = (vin64 > VMAX64) ? VMAX64 : ((vin64 < VMIN64) ? VMIN64 : vin64);

  assign ps = probe_r[0] ? SKW'(NUM_STATES) : s_r;
  assign pa = probe_r[1] ? AKW'(NUM_ACTIONS) : a_r;
  assign pn = probe_r[2] ? SKW'(NUM_STATES) : n_r;
  assign probe_addr = ADDR_W'((32'(ps) * AKEYS + 32'(pa)) * SKEYS + 32'(pn));

  assign mem_we    = (state_r == ST_CLR) || (state_r == ST_WMIN);
  assign mem_addr  = (state_r == ST_CLR) ? clr_cnt_r : probe_addr;
  assign mem_wdata = (state_r == ST_CLR) ? '0 : {1'b1, v_r};

  wrt_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (VW + 1)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign cmp_lhs = (state_r == ST_WMAX) ? max_r : v_r;
  assign cmp_rhs = (state_r == ST_WMAX) ? v_r : min_r;

  wrt_cmp #(
    .WIDTH (VW)
  ) u_cmp (
    .lhs (cmp_lhs),
    .rhs (cmp_rhs),
    .lt  (cmp_lt),
    .low (cmp_low)
  );

  assign rv64 = 64'(res_value_r);
  assign mn64 = 64'(min_r);
  assign mx64 = 64'(max_r);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_op_nxt    = clr_op_r;
    probe_nxt     = probe_r;
    s_nxt         = s_r;
    a_nxt         = a_r;
    n_nxt         = n_r;
    op_nxt        = op_r;
    v_nxt         = v_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    res_value_nxt = res_value_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_hit_nxt   = out_hit_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          s_nxt         = s_key;
          a_nxt         = a_key;
          n_nxt         = n_key;
          op_nxt        = in_opcode;
          v_nxt         = sat64[VW-1:0];
          probe_nxt     = '0;
          res_value_nxt = '0;
          res_hit_nxt   = 1'b0;
          case (in_opcode)
            OP_WRITE: state_nxt = ST_WMIN;
            OP_READ:  state_nxt = ST_RISS;
            OP_CLEAR: begin
              state_nxt   = ST_CLR;
              clr_cnt_nxt = '0;
              clr_op_nxt  = 1'b1;
              min_nxt     = VMAX;
              max_nxt     = VMIN;
            end
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt  = clr_op_r ? ST_DONE : ST_IDLE;
          clr_op_nxt = 1'b0;
        end
      end
      ST_WMIN: begin
        min_nxt   = cmp_low;
        state_nxt = ST_WMAX;
      end
      ST_WMAX: begin
        if (cmp_lt) begin
          max_nxt = v_r;
        end
        state_nxt = ST_DONE;
      end
      ST_RISS: begin
        state_nxt = ST_RCHK;
      end
      ST_RCHK: begin
        if (mem_rdata[VW]) begin
          res_value_nxt = mem_rdata[VW-1:0];
          res_hit_nxt   = 1'b1;
          state_nxt     = ST_DONE;
        end else if (probe_r == PROBE_W'(PROBES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_RISS;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rv64[IO_VAL_W-1:0];
          out_hit_nxt   = res_hit_r;
          out_min_nxt   = mn64[IO_VAL_W-1:0];
          out_max_nxt   = mx64[IO_VAL_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      clr_op_r    <= 1'b0;
      probe_r     <= '0;
      min_r       <= VMAX;
      max_r       <= VMIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_op_r    <= clr_op_nxt;
      probe_r     <= probe_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    a_r         <= a_nxt;
    n_r         <= n_nxt;
    op_r        <= op_nxt;
    v_r         <= v_nxt;
    res_value_r <= res_value_nxt;
    res_hit_r   <= res_hit_nxt;
    out_value_r <= out_value_nxt;
    out_hit_r   <= out_hit_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_hit        = out_hit_r;
  assign out_min_value  = out_min_r;
  assign out_max_value  = out_max_r;

  a_range_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WMAX |=> min_r <= max_r)
    else $error("running min above running max after a write");

  a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR && state_nxt != ST_CLR |-> clr_cnt_r == ADDR_W'(DEPTH - 1))
    else $error("clear sweep left early");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat raised outside the done step");

  a_hit_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && res_hit_r |-> op_r == OP_READ)
    else $error("hit flagged for a non-read beat");

endmodule
